// ----- rtl/ps2md_pkg.sv -----
package ps2md_pkg;

	// Kind of an input word
	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	typedef logic [7:0] byte_t;

	// Bank number inside the three-bank queue store
	typedef logic [1:0] bank_t;

	localparam int PKT_BYTES = 3;
	localparam int SYNC_BIT  = 3;
	localparam int XSIGN_BIT = 4;
	localparam int YSIGN_BIT = 5;
	localparam int BTN_W     = 3;

endpackage

// ----- rtl/ps2md_bank.sv -----
module ps2md_bank import ps2md_pkg::*; #(
	parameter int ROWS  = 86,
	parameter int ROW_W = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [ROW_W-1:0] waddr,
	input  byte_t            wdata,
	input  logic             re,
	input  logic [ROW_W-1:0] raddr,
	output byte_t            rdata
);

	byte_t mem [ROWS];

	// Write one byte
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register the read data, hold it between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/ps2md_core.sv -----
// PS/2 mouse packet decoder. Each input word is either a byte from the mouse
// (kind 0) or a request to pop one three-byte packet from the queue (kind 1);
// every accepted word gives exactly one result word. One word is taken per
// clock cycle and its result appears in the output register in the cycle after
// acceptance; the input stalls only while that register is full and the output
// is stalled. The byte queue holds QUEUE_DEPTH bytes in three byte-wide banks
// of ceil(QUEUE_DEPTH/3) rows, so a completed packet writes up to three bytes
// and a read fetches three bytes at once, each bank at one port.
// The queue needs no clearing after reset.
module ps2_mouse_packet_decoder_core import ps2md_pkg::*; #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [2:0]         button_bits,
	output logic               packet_completed,
	output logic               read_valid,
	output logic [23:0]        read_packet,
	output logic [8:0]         queued_bytes,
	output logic               packet_ready
);

	localparam int ROWS   = (QUEUE_DEPTH + 2) / 3;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	// Decoder state
	byte_t              first_q, second_q;
	logic [1:0]         idx_q;
	logic [31:0]        x_q, y_q;
	logic [BTN_W-1:0]   btn_q;
	logic [ROW_W-1:0]   wr_row_q, rd_row_q;
	bank_t              wr_bank_q, rd_bank_q;
	logic [FILL_W-1:0]  fill_q;

	// Result stage
	logic               v_s1, done_s1, pop_s1;
	bank_t              rb_s1;

	logic               accept, is_byte, complete, do_pop;
	logic [FILL_W-1:0]  room;
	logic [1:0]         push_n;
	logic [ROW_W-1:0]   wr_row_nx, rd_row_nx;
	logic [2:0]         b_we;
	logic [ROW_W-1:0]   b_waddr [3];
	logic [ROW_W-1:0]   b_raddr [3];
	byte_t              b_wdata [3];
	byte_t              b_rdata [3];
	logic [31:0]        dx, dy;
	logic [2:0]         wb_sum;
	logic [31:0]        fill_ext;

	assign in_stall = v_s1 && out_stall;
	assign accept   = in_valid && !in_stall;
	assign is_byte  = (kind_t'(kind) == KIND_BYTE);
	assign complete = is_byte && (idx_q == 2'd2);
	assign do_pop   = !is_byte && (fill_q >= FILL_W'(PKT_BYTES));

	// Bytes that fit into the queue for this packet
	assign room   = FILL_W'(QUEUE_DEPTH) - fill_q;
	assign push_n = (room >= FILL_W'(PKT_BYTES)) ? 2'(PKT_BYTES) : room[1:0];

	// Next rows with wrap
	assign wr_row_nx = (wr_row_q == ROW_W'(ROWS - 1)) ? '0 : wr_row_q + 1'b1;
	assign rd_row_nx = (rd_row_q == ROW_W'(ROWS - 1)) ? '0 : rd_row_q + 1'b1;
	assign wb_sum    = 3'(wr_bank_q) + 3'(push_n);

	// Sign-extended movement
	assign dx = {{24{first_q[XSIGN_BIT]}}, second_q};
	assign dy = {{24{first_q[YSIGN_BIT]}}, data_byte};

	// Spread packet bytes and read addresses across the banks
	always_comb begin
		bank_t woff;
		for (int j = 0; j < 3; j++) begin
			woff = (bank_t'(j) >= wr_bank_q) ? bank_t'(j) - wr_bank_q
			                                 : bank_t'(j) + 2'd3 - wr_bank_q;
			b_we[j]    = accept && complete && (woff < push_n);
			b_waddr[j] = (bank_t'(j) >= wr_bank_q) ? wr_row_q : wr_row_nx;
			b_raddr[j] = (bank_t'(j) >= rd_bank_q) ? rd_row_q : rd_row_nx;
			case (woff)
				2'd0:    b_wdata[j] = first_q;
				2'd1:    b_wdata[j] = second_q;
				default: b_wdata[j] = data_byte;
			endcase
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_bank
		ps2md_bank #(
			.ROWS  (ROWS),
			.ROW_W (ROW_W)
		) u_bank (
			.clk   (clk),
			.we    (b_we[g]),
			.waddr (b_waddr[g]),
			.wdata (b_wdata[g]),
			.re    (accept && do_pop),
			.raddr (b_raddr[g]),
			.rdata (b_rdata[g])
		);
	end

	// Advance decoder and queue state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= '0;
			second_q  <= '0;
			idx_q     <= '0;
			x_q       <= '0;
			y_q       <= '0;
			btn_q     <= '0;
			wr_row_q  <= '0;
			rd_row_q  <= '0;
			wr_bank_q <= '0;
			rd_bank_q <= '0;
			fill_q    <= '0;
		end else if (accept) begin
			if (is_byte) begin
				case (idx_q)
					2'd0: begin
						if (data_byte[SYNC_BIT]) begin
							first_q <= data_byte;
							idx_q   <= 2'd1;
						end
					end
					2'd1: begin
						second_q <= data_byte;
						idx_q    <= 2'd2;
					end
					default: begin
						idx_q  <= 2'd0;
						x_q    <= x_q + dx;
						y_q    <= y_q - dy;
						btn_q  <= first_q[BTN_W-1:0];
						fill_q <= fill_q + FILL_W'(push_n);
						if (wb_sum >= 3'd3 || push_n == 2'(PKT_BYTES)) begin
							wr_bank_q <= (push_n == 2'(PKT_BYTES)) ? wr_bank_q
							                                       : 2'(wb_sum - 3'd3);
							wr_row_q  <= wr_row_nx;
						end else begin
							wr_bank_q <= wb_sum[1:0];
						end
					end
				endcase
			end else if (do_pop) begin
				rd_row_q <= rd_row_nx;
				fill_q   <= fill_q - FILL_W'(PKT_BYTES);
			end
		end
	end

	// Result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (!out_stall) begin
			v_s1 <= 1'b0;
		end
	end

	// Result stage flags
	always_ff @(posedge clk) begin
		if (accept) begin
			done_s1 <= complete;
			pop_s1  <= do_pop;
			rb_s1   <= rd_bank_q;
		end
	end

	// Rotate bank data back into packet order
	always_comb begin
		bank_t k;
		read_packet = '0;
		for (int i = 0; i < 3; i++) begin
			k = (rb_s1 + bank_t'(i) >= 2'd3) ? rb_s1 + bank_t'(i) - 2'd3
			                                 : rb_s1 + bank_t'(i);
			if (pop_s1) begin
				read_packet[i*8 +: 8] = b_rdata[k];
			end
		end
	end

	assign fill_ext         = 32'(fill_q);
	assign out_valid        = v_s1;
	assign pos_x            = x_q;
	assign pos_y            = y_q;
	assign button_bits      = btn_q;
	assign packet_completed = done_s1;
	assign read_valid       = pop_s1;
	assign queued_bytes     = fill_ext[8:0];
	assign packet_ready     = (fill_q >= FILL_W'(PKT_BYTES));

endmodule

// ----- bench/ps2_mouse_packet_decoder_core_checker.sv -----
`timescale 1ns / 1ps
module ps2_mouse_packet_decoder_core_checker import ps2md_pkg::*; #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               kind,
	input  logic [7:0]         data_byte,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [2:0]         button_bits,
	input  logic               packet_completed,
	input  logic               read_valid,
	input  logic [23:0]        read_packet,
	input  logic [8:0]         queued_bytes,
	input  logic               packet_ready,
	output int                 fault_count,
	output int                 reports_due
);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [2:0]         buttons;
		logic               completed;
		logic               popped;
		logic [23:0]        packet;
		logic [8:0]         queued;
		logic               ready;
	} mouse_report_t;

	// Decoder state as seen from outside
	mouse_report_t due_reports[$];
	byte_t         head_byte;
	byte_t         dx_byte;
	logic [1:0]    byte_slot;
	logic [31:0]   x_acc;
	logic [31:0]   y_acc;
	logic [2:0]    btn_state;
	byte_t         byte_fifo[QUEUE_DEPTH];
	int            fifo_wr;
	int            fifo_rd;
	int            fifo_fill;
	int            report_no;

	// Work out the report for one word and advance the decoder state
	task automatic decode_word(input kind_t k, input byte_t b, output mouse_report_t r);
		byte_t trio[PKT_BYTES];
		int    n;
		r = '0;
		if (k == KIND_BYTE) begin
			if (byte_slot == 2'd0) begin
				// drop a start byte that lacks the sync bit
				if (b[SYNC_BIT]) begin
					head_byte = b;
					byte_slot = 2'd1;
				end
			end else if (byte_slot == 2'd1) begin
				dx_byte   = b;
				byte_slot = 2'd2;
			end else begin
				trio = '{head_byte, dx_byte, b};
				// each byte that finds the queue full is lost on its own
				for (n = 0; n < PKT_BYTES; n++) begin
					if (fifo_fill < QUEUE_DEPTH) begin
						byte_fifo[fifo_wr] = trio[n];
						fifo_wr = (fifo_wr + 1) % QUEUE_DEPTH;
						fifo_fill++;
					end
				end
				x_acc += {{24{head_byte[XSIGN_BIT]}}, dx_byte};
				y_acc -= {{24{head_byte[YSIGN_BIT]}}, b};
				btn_state   = head_byte[BTN_W-1:0];
				byte_slot   = 2'd0;
				r.completed = 1'b1;
			end
		end else if (fifo_fill >= PKT_BYTES) begin
			for (n = 0; n < PKT_BYTES; n++) begin
				r.packet[8*n +: 8] = byte_fifo[fifo_rd];
				fifo_rd = (fifo_rd + 1) % QUEUE_DEPTH;
				fifo_fill--;
			end
			r.popped = 1'b1;
		end
		r.x       = x_acc;
		r.y       = y_acc;
		r.buttons = btn_state;
		r.queued  = 9'(fifo_fill);
		r.ready   = fifo_fill >= PKT_BYTES;
	endtask

	task automatic check_field(input string tag, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			if (fault_count < 10)
				$display("report %0d: %s expected %0h, got %0h", report_no, tag, want, got);
			fault_count++;
		end
	endtask

	// Compare each report word with the oldest prediction, then predict the new one
	always @(posedge clk) begin : watch
		mouse_report_t want;
		if (!arst_n) begin
			due_reports.delete();
			head_byte   = '0;
			dx_byte     = '0;
			byte_slot   = '0;
			x_acc       = '0;
			y_acc       = '0;
			btn_state   = '0;
			fifo_wr     = 0;
			fifo_rd     = 0;
			fifo_fill   = 0;
			report_no   = 0;
			fault_count = 0;
			reports_due = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_reports.size() == 0) begin
					if (fault_count < 10)
						$display("report %0d: no word was due", report_no);
					fault_count++;
				end else begin
					want = due_reports.pop_front();
					check_field("pos_x", want.x, pos_x);
					check_field("pos_y", want.y, pos_y);
					check_field("button_bits", 32'(want.buttons), 32'(button_bits));
					check_field("packet_completed", 32'(want.completed), 32'(packet_completed));
					check_field("read_valid", 32'(want.popped), 32'(read_valid));
					check_field("read_packet", 32'(want.packet), 32'(read_packet));
					check_field("queued_bytes", 32'(want.queued), 32'(queued_bytes));
					check_field("packet_ready", 32'(want.ready), 32'(packet_ready));
				end
				report_no++;
			end
			if (in_valid && !in_stall) begin
				decode_word(kind_t'(kind), data_byte, want);
				due_reports.push_back(want);
			end
			reports_due = due_reports.size();
		end
	end

endmodule

// ----- bench/ps2_mouse_packet_decoder_core_test.sv -----
`timescale 1ns / 1ps
module ps2_mouse_packet_decoder_core_test;
	import ps2md_pkg::*;

	localparam int QUEUE_DEPTH = 256;
	localparam int WORD_TOTAL  = 1350;
	localparam int STILL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT     = 1100;

	typedef struct {
		kind_t k;
		byte_t b;
	} mouse_word_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	kind_t              kind      = KIND_BYTE;
	byte_t              data_byte = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [2:0]         button_bits;
	logic               packet_completed;
	logic               read_valid;
	logic [23:0]        read_packet;
	logic [8:0]         queued_bytes;
	logic               packet_ready;
	int                 fault_count;
	int                 reports_due;

	mouse_word_t script[$];
	int          next_word    = 0;
	int          words_taken  = 0;
	int          still_cycles = 0;
	int          hold_left    = 0;
	bit          hold_done    = 1'b0;
	logic        calm;

	always #5 clk = ~clk;

	// no idling on either side for a stretch in the middle of the run
	assign calm = words_taken >= 700 && words_taken < 950;

	ps2_mouse_packet_decoder_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.button_bits(button_bits),
		.packet_completed(packet_completed),
		.read_valid(read_valid),
		.read_packet(read_packet),
		.queued_bytes(queued_bytes),
		.packet_ready(packet_ready)
	);

	ps2_mouse_packet_decoder_core_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) i_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.button_bits(button_bits),
		.packet_completed(packet_completed),
		.read_valid(read_valid),
		.read_packet(read_packet),
		.queued_bytes(queued_bytes),
		.packet_ready(packet_ready),
		.fault_count(fault_count),
		.reports_due(reports_due)
	);

	task automatic plan_word(input kind_t k, input byte_t b);
		script.push_back('{k, b});
	endtask

	task automatic plan_packet(input byte_t head, input byte_t dx, input byte_t dy);
		plan_word(KIND_BYTE, head);
		plan_word(KIND_BYTE, dx);
		plan_word(KIND_BYTE, dy);
	endtask

	// Build the word script, run it and give the verdict
	initial begin
		byte_t head;
		int    read_pct;
		// read from an empty queue, then start bytes without the sync bit
		plan_word(KIND_READ, 8'hFF);
		plan_word(KIND_BYTE, 8'h00);
		plan_word(KIND_BYTE, 8'hF7);
		// zero motion, most negative deltas, minus one, largest positive deltas
		plan_packet(8'h08, 8'h00, 8'h00);
		plan_packet(8'h3F, 8'h00, 8'h00);
		plan_packet(8'h38, 8'hFF, 8'hFF);
		plan_packet(8'hCF, 8'hFF, 8'hFF);
		// drain all four packets, last read finds the queue empty
		repeat (5) plan_word(KIND_READ, 8'h00);
		// overfill the queue so that bytes are dropped and packets split
		repeat (100) begin
			head = 8'($urandom) | 8'(1 << SYNC_BIT);
			plan_packet(head, 8'($urandom), 8'($urandom));
		end
		// empty it again, with reads left over on a short queue
		repeat (95) plan_word(KIND_READ, 8'($urandom));
		// mostly well-formed packets, some loose bytes, read rate varied per block
		while (script.size() < WORD_TOTAL) begin
			case ($urandom_range(0, 3))
			0: read_pct = 5;
			1: read_pct = 25;
			2: read_pct = 40;
			default: read_pct = 70;
			endcase
			for (int n = 0; n < 90 && script.size() < WORD_TOTAL; n++) begin
				if ($urandom_range(0, 99) < read_pct) begin
					plan_word(KIND_READ, 8'($urandom));
				end else if ($urandom_range(0, 9) == 0) begin
					plan_word(KIND_BYTE, 8'($urandom));
				end else begin
					head = 8'($urandom) | 8'(1 << SYNC_BIT);
					plan_packet(head, 8'($urandom), 8'($urandom));
				end
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (words_taken == script.size() && reports_due == 0);
		repeat (8) @(posedge clk);
		if (fault_count == 0 && reports_due == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Offer the next word, with random gaps outside the calm stretch, whenever the current one has gone or none is held
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (next_word < script.size() && (calm || $urandom_range(0, 99) >= 12)) begin
				in_valid  <= 1'b1;
				kind      <= script[next_word].k;
				data_byte <= script[next_word].b;
				next_word <= next_word + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the output at random, and once hold it off long enough to back up the input
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && words_taken >= HOLD_AT) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= !calm && $urandom_range(0, 99) < 12;
		end
	end

	// Count accepted words and watch for a stuck channel
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			words_taken <= words_taken + 1;
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			still_cycles <= 0;
		end else if (still_cycles == STILL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			still_cycles <= still_cycles + 1;
		end
	end

endmodule

// ----- ps2_mouse_packet_decoder_core.f -----
rtl/ps2md_pkg.sv
rtl/ps2md_bank.sv
rtl/ps2md_core.sv
bench/ps2_mouse_packet_decoder_core_checker.sv
bench/ps2_mouse_packet_decoder_core_test.sv
